>>> hdl/irpt_pkg.sv
// ----------------------------------------------------------------------------
// irpt_pkg: shared types and constants for the IR pulse train transmitter
// Field widths, item kind codes and the duration table write port bundle.
// ----------------------------------------------------------------------------
package irpt_pkg;

  // Table geometry
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int DUR_W       = 16;

  // Duration tick granularity and the elapsed-tick counter
  localparam int TICK_US     = 10;
  localparam int COUNT_W     = 13;
  localparam int PROD_W      = COUNT_W + $clog2(TICK_US + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_ENTRIES);

  // Input beat kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD    = 2'd0;
  localparam kind_t KIND_START   = 2'd1;
  localparam kind_t KIND_TICK    = 2'd2;
  localparam kind_t KIND_CARRIER = 2'd3;

  // Stream payload widths
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 8;

  // Duration table write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DUR_W-1:0]  data;
  } irpt_wr_t;

endpackage

>>> hdl/irpt_duration_mem.sv
// ----------------------------------------------------------------------------
// irpt_duration_mem: mark/space duration table
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module irpt_duration_mem (
  input  logic                         clk,
  input  irpt_pkg::irpt_wr_t           wr,
  input  logic [irpt_pkg::ADDR_W-1:0]  rd_addr,
  output logic [irpt_pkg::DUR_W-1:0]   rd_data
);
  import irpt_pkg::*;

  logic [DUR_W-1:0] mem [MAX_ENTRIES];

  // Store a loaded duration
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read every cycle, new data wins on an address match
  always_ff @(posedge clk) begin
    if (wr.en && wr.addr == rd_addr) begin
      rd_data <= wr.data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ir_pulse_train_transmitter_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_train_transmitter_unit: IR raw pulse transmitter with carrier
// Plays a table of mark/space durations as a carrier-modulated emitter level.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser carries the beat kind (load, start, duration
//   tick, carrier tick); tdata carries entry_slot, duration_us and
//   sequence_length. Loads fill the duration table, a start begins sending
//   the first sequence_length entries, duration ticks pace the marks and
//   spaces, carrier ticks toggle the carrier phase.
//   Output stream (m_*): one beat per input beat with the emitter level,
//   the busy flag and the mark gate as they stand after that input beat.
//   Output valid follows input acceptance in the next cycle, and one input beat
//   is taken every cycle while the receiver keeps up. The table read for the
//   entry in play is prefetched by a registered memory port, so ticks run
//   back to back. While the receiver stalls, the output register holds its
//   beat and the input is taken again as soon as that beat leaves.
//   Reset clears the control state and the output valid flag; the duration
//   table is not cleared and must be loaded before it is sent.
// ----------------------------------------------------------------------------
module ir_pulse_train_transmitter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] entry_slot, [23:8] duration_us, [32:24] sequence_length, zero pad
  input  logic [irpt_pkg::S_DATA_W-1:0] s_tdata,
  // [1:0] kind
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] ir_level, [1] busy_res, [2] mark_gate, zero pad
  output logic [irpt_pkg::M_DATA_W-1:0] m_tdata
);
  import irpt_pkg::*;

  // Input fields
  kind_t             kind;
  logic [ADDR_W-1:0] entry_slot;
  logic [DUR_W-1:0]  duration_us;
  logic [LEN_W-1:0]  sequence_length;

  assign kind            = s_tuser;
  assign entry_slot      = s_tdata[ADDR_W-1:0];
  assign duration_us     = s_tdata[8 +: DUR_W];
  assign sequence_length = s_tdata[24 +: LEN_W];

  // Transmitter state
  logic [LEN_W-1:0]   length_in_use, length_in_use_next;
  logic               sending, sending_next;
  logic               gate, gate_next;
  logic [LEN_W-1:0]   position, position_next;
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic               carrier_phase, carrier_phase_next;
  logic               drive_level, drive_level_next;

  logic               accept;
  logic [DUR_W-1:0]   cur_dur;
  logic [PROD_W-1:0]  elapsed_us;
  logic               in_range;
  irpt_wr_t           tbl_wr;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Table write from load beats
  always_comb begin
    tbl_wr.en   = accept && kind == KIND_LOAD;
    tbl_wr.addr = entry_slot;
    tbl_wr.data = duration_us;
  end

  // Prefetch the entry at the next position
  irpt_duration_mem u_mem (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (position_next[ADDR_W-1:0]),
    .rd_data (cur_dur)
  );

  assign elapsed_us = PROD_W'(tick_count) * PROD_W'(TICK_US);
  assign in_range   = position < length_in_use && position < LEN_MAX;

  // Next state for the accepted beat
  always_comb begin
    length_in_use_next = length_in_use;
    sending_next       = sending;
    gate_next          = gate;
    position_next      = position;
    tick_count_next    = tick_count;
    carrier_phase_next = carrier_phase;
    drive_level_next   = drive_level;
    if (accept) begin
      case (kind)
        KIND_LOAD: begin
        end
        KIND_START: begin
          length_in_use_next = (sequence_length > LEN_MAX) ? LEN_MAX : sequence_length;
          gate_next          = 1'b1;
          position_next      = '0;
          tick_count_next    = '0;
          sending_next       = 1'b1;
        end
        KIND_TICK: begin
          if (sending) begin
            if (in_range) begin
              if (tick_count != COUNT_MAX && elapsed_us < PROD_W'(cur_dur)) begin
                tick_count_next = tick_count + 1'b1;
              end else begin
                gate_next       = !gate;
                tick_count_next = COUNT_W'(1);
                position_next   = position + 1'b1;
              end
            end else begin
              sending_next     = 1'b0;
              drive_level_next = 1'b0;
            end
          end
        end
        KIND_CARRIER: begin
          carrier_phase_next = !carrier_phase;
          if (sending) begin
            drive_level_next = gate && !carrier_phase;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Update state
  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= '0;
      sending       <= 1'b0;
      gate          <= 1'b0;
      position      <= '0;
      tick_count    <= '0;
      carrier_phase <= 1'b0;
      drive_level   <= 1'b0;
    end else begin
      length_in_use <= length_in_use_next;
      sending       <= sending_next;
      gate          <= gate_next;
      position      <= position_next;
      tick_count    <= tick_count_next;
      carrier_phase <= carrier_phase_next;
      drive_level   <= drive_level_next;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'b0, gate_next, sending_next, drive_level_next};
    end
  end

  // Checks
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= length_in_use)
    else $error("position beyond sequence length");

  a_stop_low: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_TICK && sending && !in_range |=> !sending && !drive_level)
    else $error("end of sequence did not stop and drive low");

  a_out_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted beat produced no output beat");

  a_start_gate: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_START |=> sending && gate && position == '0)
    else $error("start did not arm the sequence");

endmodule

>>> sim/tb_ir_pulse_train_transmitter_unit.sv
// ----------------------------------------------------------------------------
// tb_ir_pulse_train_transmitter_unit: self-checking bench for the IR transmitter
// Drives load, start, duration tick and carrier tick beats under random idling
// and receiver hold-off, tracks the emitter state in a scoreboard and compares
// every output beat with the predicted level, busy flag and mark gate.
// ----------------------------------------------------------------------------
module tb_ir_pulse_train_transmitter_unit;
  import irpt_pkg::*;

  localparam int unsigned TOTAL_ITEMS = 1650;
  localparam int unsigned PHASE_ITEMS = 550;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_OFF    = 80;

  // Emitter outputs as they stand after one input beat
  typedef struct packed {
    logic mark;
    logic busy;
    logic level;
  } emitter_beat_t;

  // Tracks the transmitter state and the output beats still owed by the block
  class emitter_scoreboard;
    logic [DUR_W-1:0]   durations [MAX_ENTRIES];
    logic [LEN_W-1:0]   run_len   = '0;
    logic [LEN_W-1:0]   entry_idx = '0;
    logic [COUNT_W-1:0] elapsed   = '0;
    logic               sending   = 1'b0;
    logic               mark_on   = 1'b0;
    logic               phase     = 1'b0;
    logic               level     = 1'b0;
    emitter_beat_t      states_due [$];
    int unsigned        errors    = 0;

    // Apply one accepted input beat and queue the state it leaves behind
    function void advance_emitter(kind_t kind, logic [7:0] slot, logic [15:0] dur,
                                  logic [8:0] len);
      case (kind)
        KIND_LOAD: begin
          durations[slot] = dur;
        end
        KIND_START: begin
          run_len   = (len > MAX_ENTRIES) ? LEN_MAX : len;
          mark_on   = 1'b1;
          entry_idx = '0;
          elapsed   = '0;
          sending   = 1'b1;
        end
        KIND_TICK: begin
          if (sending) begin
            if (entry_idx < run_len) begin
              // count within the entry, or move on once it has elapsed
              if (elapsed != COUNT_MAX &&
                  32'(elapsed) * TICK_US < 32'(durations[entry_idx[ADDR_W-1:0]])) begin
                elapsed = elapsed + 1'b1;
              end else begin
                mark_on   = ~mark_on;
                elapsed   = COUNT_W'(1);
                entry_idx = entry_idx + 1'b1;
              end
            end else begin
              sending = 1'b0;
              level   = 1'b0;
            end
          end
        end
        default: begin
          phase = ~phase;
          if (sending) level = mark_on ? phase : 1'b0;
        end
      endcase
      states_due.push_back('{mark: mark_on, busy: sending, level: level});
    endfunction

    // Compare one output beat with the oldest owed state
    function void check_beat(logic [M_DATA_W-1:0] data);
      emitter_beat_t want;
      if (states_due.size() == 0) begin
        $error("output beat %0h arrived with nothing owed", data);
        errors++;
        return;
      end
      want = states_due.pop_front();
      if (data[0] !== want.level) begin
        $error("ir_level: expected %0b, actual %0b", want.level, data[0]);
        errors++;
      end
      if (data[1] !== want.busy) begin
        $error("busy_res: expected %0b, actual %0b", want.busy, data[1]);
        errors++;
      end
      if (data[2] !== want.mark) begin
        $error("mark_gate: expected %0b, actual %0b", want.mark, data[2]);
        errors++;
      end
      if (data[M_DATA_W-1:3] !== '0) begin
        $error("pad: expected 0, actual %0h", data[M_DATA_W-1:3]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return states_due.size();
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [1:0]          s_tuser  = KIND_LOAD;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  emitter_scoreboard tracker = new;

  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 84;
  bit          hold_off_req  = 1'b0;
  int unsigned items_sent    = 0;
  bit          slot_loaded [MAX_ENTRIES];

  ir_pulse_train_transmitter_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one beat after a random gap and hold it until the block takes it
  task automatic send_item(kind_t kind, logic [7:0] slot, logic [15:0] dur,
                           logic [8:0] len);
    if (items_sent == PHASE_ITEMS) begin
      send_idle_pct = 84;
      recv_idle_pct = 29;
    end else if (items_sent == 2 * PHASE_ITEMS) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off_req  = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= S_DATA_W'({len, dur, slot});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == KIND_LOAD) slot_loaded[slot] = 1'b1;
    items_sent++;
  endtask

  // First slot never loaded; starts may only send the slots below it
  function automatic int unsigned loaded_prefix();
    int unsigned idx;
    idx = 0;
    while (idx < MAX_ENTRIES && slot_loaded[idx]) idx++;
    return idx;
  endfunction

  function automatic logic [8:0] pick_length();
    int unsigned top;
    top = loaded_prefix();
    if (top == MAX_ENTRIES && $urandom_range(99) < 20) return 9'($urandom_range(511, 256));
    return 9'($urandom_range(top < 12 ? top : 12, 0));
  endfunction

  function automatic logic [15:0] short_duration();
    if ($urandom_range(99) < 80) return 16'($urandom_range(40));
    return 16'($urandom_range(300, 41));
  endfunction

  // Mostly extend the loaded prefix; now and then park a full-range value and rewrite it
  task automatic load_entry();
    int unsigned top;
    logic [7:0]  slot;
    top  = loaded_prefix();
    slot = (top < MAX_ENTRIES && $urandom_range(99) < 70) ? 8'(top) : 8'($urandom_range(255));
    if ($urandom_range(99) < 6)
      send_item(KIND_LOAD, slot, 16'($urandom_range(65535)), 9'($urandom_range(511)));
    send_item(KIND_LOAD, slot, short_duration(), 9'($urandom_range(511)));
  endtask

  // Tick-type beat with random payload in the ignored fields
  task automatic tick_item(kind_t kind);
    send_item(kind, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              9'($urandom_range(511)));
  endtask

  task automatic start_item();
    send_item(KIND_START, 8'($urandom_range(255)), 16'($urandom_range(65535)), pick_length());
  endtask

  // Run the transmitter with ticks, an occasional restart or reload
  task automatic tick_stream(int unsigned count);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 65)      tick_item(KIND_TICK);
      else if (roll < 95) tick_item(KIND_CARRIER);
      else if (roll < 98) start_item();
      else                load_entry();
    end
  endtask

  // Fill the whole table with short entries and send it with a saturating length
  task automatic full_table_send();
    for (int unsigned s = loaded_prefix(); s < MAX_ENTRIES; s++)
      send_item(KIND_LOAD, 8'(s), 16'($urandom_range(3)), 9'($urandom_range(511)));
    send_item(KIND_START, 8'($urandom_range(255)), 16'($urandom_range(65535)),
              9'($urandom_range(511, 256)));
    repeat (560) tick_item(($urandom_range(99) < 85) ? KIND_TICK : KIND_CARRIER);
  endtask

  // Receiver: random stalls, plus one long hold-off so the input backs up
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Sample both handshakes, feed the scoreboard and watch for a hung block
  initial begin : beat_monitor
    int unsigned quiet_cycles;
    logic        took_in;
    logic        took_out;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      took_in  = !rst && s_tvalid && s_tready;
      took_out = !rst && m_tvalid && m_tready;
      if (took_in)
        tracker.advance_emitter(kind_t'(s_tuser), s_tdata[7:0], s_tdata[23:8],
                                s_tdata[32:24]);
      if (took_out) tracker.check_beat(m_tdata);
      quiet_cycles = (took_in || took_out) ? 0 : quiet_cycles + 1;
    end
    $display("tb_ir_pulse_train_transmitter_unit failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned roll;
    bit          table_sent;
    table_sent = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // ticks while idle: phase moves, level holds low
    send_item(KIND_CARRIER, 8'hff, 16'hffff, 9'h1ff);
    send_item(KIND_TICK, 8'h00, 16'h0000, 9'h000);
    // table extremes; the top slot gets rewritten to a short entry
    send_item(KIND_LOAD, 8'd0, 16'd0, 9'h1ff);
    send_item(KIND_LOAD, 8'd1, 16'd25, 9'h000);
    send_item(KIND_LOAD, 8'd255, 16'hffff, 9'h000);
    send_item(KIND_LOAD, 8'd255, 16'd7, 9'h000);
    // zero length: busy until the first duration tick
    send_item(KIND_START, 8'd0, 16'd0, 9'd0);
    send_item(KIND_CARRIER, 8'd0, 16'd0, 9'd0);
    send_item(KIND_TICK, 8'd0, 16'd0, 9'd0);
    // two entries: zero duration, then 25 us; gate toggles between carrier ticks
    send_item(KIND_START, 8'd0, 16'd0, 9'd2);
    send_item(KIND_CARRIER, 8'd0, 16'd0, 9'd0);
    send_item(KIND_TICK, 8'd0, 16'd0, 9'd0);
    send_item(KIND_CARRIER, 8'd0, 16'd0, 9'd0);
    repeat (4) send_item(KIND_TICK, 8'd0, 16'd0, 9'd0);
    send_item(KIND_CARRIER, 8'd0, 16'd0, 9'd0);
    // restart once the sequence has ended: level waits for the next carrier tick
    send_item(KIND_START, 8'd0, 16'd0, 9'd1);
    repeat (3) send_item(KIND_TICK, 8'd0, 16'd0, 9'd0);
    send_item(KIND_CARRIER, 8'd0, 16'd0, 9'd0);

    // random rounds: mostly load, start, tick; some bare noise
    while (items_sent < TOTAL_ITEMS) begin
      roll = $urandom_range(99);
      if (!table_sent && items_sent >= 300) begin
        full_table_send();
        table_sent = 1'b1;
      end else if (roll < 12) begin
        repeat ($urandom_range(15, 3)) begin
          roll = $urandom_range(99);
          if (roll < 40)      tick_item(KIND_TICK);
          else if (roll < 80) tick_item(KIND_CARRIER);
          else                load_entry();
        end
      end else begin
        repeat ($urandom_range(6, 1)) load_entry();
        start_item();
        tick_stream($urandom_range(60, 4));
      end
    end

    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb_ir_pulse_train_transmitter_unit passed");
    else
      $display("tb_ir_pulse_train_transmitter_unit failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/irpt_pkg.sv
hdl/irpt_duration_mem.sv
hdl/ir_pulse_train_transmitter_unit.sv
sim/tb_ir_pulse_train_transmitter_unit.sv
